// File: hdl/dmif_pkg.sv
// Shared constants and types for the diamond mean image filter.
package dmif_pkg;

    localparam int PIX_W        = 8;
    localparam int HALF_W       = 3;
    localparam int DIM_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int MAX_HALF_DEF = 7;
    localparam int MAX_COLS_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;

    // Per-cycle commands broadcast to every window cell
    typedef struct packed {
        logic shift_row;
        logic push_col;
        logic acc_clr;
        logic acc_en;
        logic chain_en;
    } t_cell_ctl;

endpackage

// File: hdl/dmif_cell.sv
// One window row: pixel registers, masked row accumulator and partial-sum stage.
module dmif_cell import dmif_pkg::*; #(
    parameter int WIN      = 15,
    parameter int CELL_IDX = 0,
    parameter int POS_W    = 4,
    parameter int ACC_W    = 12,
    parameter int SUM_W    = 15
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [POS_W-1:0] i_pos,
    input  logic [POS_W-1:0] i_ctr,
    input  logic [POS_W-1:0] i_half,
    input  logic [PIX_W-1:0] i_col,
    output logic [PIX_W-1:0] o_col,
    input  logic [SUM_W-1:0] i_psum,
    output logic [SUM_W-1:0] o_psum
);

    localparam logic [POS_W-1:0] IDX = POS_W'(CELL_IDX);

    logic [PIX_W-1:0] r_row [WIN];
    logic [ACC_W-1:0] r_acc;
    logic [SUM_W-1:0] r_psum;
    logic [POS_W-1:0] dy;
    logic [POS_W-1:0] dx;
    logic             hit;

    assign dy  = (IDX >= i_ctr) ? IDX - i_ctr : i_ctr - IDX;
    assign dx  = (i_pos >= i_ctr) ? i_pos - i_ctr : i_ctr - i_pos;
    assign hit = ({1'b0, dx} + {1'b0, dy}) <= {1'b0, i_half};

    // Shift the row left, then take the new right-hand pixel from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_row) begin
            for (int p = 0; p < WIN - 1; p++) begin
                r_row[p] <= r_row[p+1];
            end
        end
        if (i_ctl.push_col) begin
            r_row[WIN-1] <= i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en && hit) begin
            r_acc <= r_acc + ACC_W'(r_row[i_pos]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.chain_en) begin
            r_psum <= i_psum + SUM_W'(r_acc);
        end
    end

    assign o_col  = r_row[WIN-1];
    assign o_psum = r_psum;

endmodule

// File: hdl/dmif_div.sv
// Divide by the diamond mask count through a table of reciprocals and one multiply.
module dmif_div import dmif_pkg::*; #(
    parameter int MAX_HALF = MAX_HALF_DEF,
    parameter int HIDX_W   = 3,
    parameter int NUM_W    = 15,
    parameter int DEN_W    = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [HIDX_W-1:0] i_half,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quo
);

    // Shift wide enough that the rounded-up reciprocal is exact for every numerator
    localparam int SHIFT  = NUM_W + DEN_W;
    localparam int REC_W  = SHIFT + 1;
    localparam int PROD_W = NUM_W + REC_W;

    logic [REC_W-1:0]  w_recip [MAX_HALF+1];
    logic              r_busy;
    logic              r_done;
    logic [NUM_W-1:0]  r_num;
    logic [REC_W-1:0]  r_rec;
    logic [NUM_W-1:0]  r_quo;
    logic [PROD_W-1:0] prod;

    for (genvar g = 0; g <= MAX_HALF; g++) begin : g_recip
        localparam longint MASK  = longint'(2 * g * g + 2 * g + 1);
        localparam longint RECIP = ((longint'(1) << SHIFT) + MASK - 1) / MASK;
        assign w_recip[g] = REC_W'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    assign prod = PROD_W'(r_num) * PROD_W'(r_rec);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rec <= w_recip[i_half];
        end
        if (r_busy) begin
            r_quo <= prod[SHIFT +: NUM_W];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: hdl/diamond_mean_image_filter_unit.sv
// Top level of the diamond mean image filter: line store, window cell chain, divider.
//
// Pixels arrive in raster order on the slave stream, one word each. Every pixel first
// goes through the line-store phase (span = 2h), where one read port and one write
// port of the line memory walk the 2h stored lines at its column. If the pixel completes
// a window, the cell chain then makes one pass to accumulate each masked row and one
// pass to ripple the partial sums through the cells, followed by a launch state, the
// reciprocal-multiply divider and the load of the output register, which waits while
// that register holds a result the sink has not taken. The input is taken one word at
// a time; a finished result waits in the output register while the next pixel is
// already being worked on. Writing any configuration register restarts the frame
// position at row 0, column 0; stored pixels are kept. h above MAX_HALF is clamped,
// zero sizes act as one, and a row longer than MAX_COLS acts as MAX_COLS.
module diamond_mean_image_filter_unit import dmif_pkg::*; #(
    parameter int MAX_HALF = MAX_HALF_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [PIX_W-1:0]     i_s_axis_tdata,    // [7:0] pixel
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [PIX_W-1:0]     o_m_axis_tdata,    // [7:0] mean_value
    output logic                 o_m_axis_tlast,    // frame_last
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam int WIN      = 2 * MAX_HALF + 1;
    localparam int LINES    = 2 * MAX_HALF;
    localparam int POS_W    = $clog2(WIN);
    localparam int K_W      = $clog2(WIN + 1);
    localparam int HIDX_W   = $clog2(MAX_HALF + 1);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CMP_W    = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int DEPTH    = LINES * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int AW2      = $clog2((LINES + 2) * MAX_COLS);
    localparam int MASK_MAX = 2 * MAX_HALF * MAX_HALF + 2 * MAX_HALF + 1;
    localparam int PIX_MAX  = (1 << PIX_W) - 1;
    localparam int SUM_W    = $clog2(PIX_MAX * MASK_MAX + 1);
    localparam int ACC_W    = $clog2(PIX_MAX * WIN + 1);
    localparam int CNT_W    = $clog2(MASK_MAX + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_CHAIN = 3'd3;
    localparam logic [2:0] S_DIVGO = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    // Configuration registers
    logic [HALF_W-1:0] r_half;
    logic [DIM_W-1:0]  r_cols;
    logic [DIM_W-1:0]  r_rows;

    // Frame position and control
    logic [COL_W-1:0]  r_col;
    logic [DIM_W-1:0]  r_row;
    logic [2:0]        r_state;
    logic [K_W-1:0]    r_k;
    logic [POS_W-1:0]  r_j;
    logic              r_prod;
    logic              r_last;
    logic [PIX_W-1:0]  r_pix;
    logic [AW2-1:0]    r_addr;
    logic [PIX_W-1:0]  r_rd_data;
    logic              r_out_vld;
    logic [PIX_W-1:0]  r_out_data;
    logic              r_out_last;

    logic [PIX_W-1:0]  r_line [DEPTH];

    logic [POS_W-1:0]  h_eff;
    logic [POS_W-1:0]  span;
    logic [POS_W-1:0]  ctr;
    logic [DIM_W-1:0]  cols_eff;
    logic [DIM_W-1:0]  rows_eff;
    logic [K_W-1:0]    k_end;
    logic              accept;
    logic              col_end;
    logic              row_end;
    logic              produce;
    logic              mem_re;
    logic              mem_we;
    logic [AW2-1:0]    waddr;
    logic [PIX_W-1:0]  push_data;
    logic              out_load;
    t_cell_ctl         ctl;
    logic              dv_start;
    logic              dv_done;
    logic [SUM_W-1:0]  dv_quo;

    logic [PIX_W-1:0]  w_col  [WIN];
    logic [SUM_W-1:0]  w_psum [WIN];

    // Effective sizes after clamping
    assign h_eff    = (int'(r_half) > MAX_HALF) ? POS_W'(MAX_HALF) : POS_W'(r_half);
    assign span     = POS_W'({h_eff, 1'b0});
    assign ctr      = POS_W'(2 * MAX_HALF) - h_eff;
    assign cols_eff = (r_cols == '0) ? DIM_W'(1) :
                      ((int'(r_cols) > MAX_COLS) ? DIM_W'(MAX_COLS) : r_cols);
    assign rows_eff = (r_rows == '0) ? DIM_W'(1) : r_rows;
    assign k_end    = K_W'(span) + K_W'(1);

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign col_end  = (CMP_W'(r_col) + CMP_W'(1)) == CMP_W'(cols_eff);
    assign row_end  = ({1'b0, r_row} + (DIM_W + 1)'(1)) == {1'b0, rows_eff};
    assign produce  = (r_row >= DIM_W'(span)) && (CMP_W'(r_col) >= CMP_W'(span));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_W'(1);
            r_cols <= DIM_W'(1024);
            r_rows <= DIM_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF: r_half <= i_cfg_data[HALF_W-1:0];
                CFG_COLS: r_cols <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Frame position; any register write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we && (i_cfg_idx == CFG_HALF || i_cfg_idx == CFG_COLS ||
                                  i_cfg_idx == CFG_ROWS)) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + DIM_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Latch the word and its position flags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix  <= i_s_axis_tdata;
            r_prod <= produce;
            r_last <= col_end && row_end;
        end
    end

    // Line store walk: step k reads line k, writes line k-2 (pixel into line span-1)
    assign mem_re    = (r_state == S_LOAD) && (r_k < K_W'(span));
    assign mem_we    = (r_state == S_LOAD) && (r_k >= K_W'(2)) && (r_k <= k_end);
    assign waddr     = r_addr - AW2'(2 * MAX_COLS);
    assign push_data = (r_k == k_end) ? r_pix : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= AW2'(r_col);
        end else if (r_state == S_LOAD) begin
            r_addr <= r_addr + AW2'(MAX_COLS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line[ADDR_W'(waddr)] <= push_data;
        end
        if (mem_re) begin
            r_rd_data <= r_line[ADDR_W'(r_addr)];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_j     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LOAD;
                        r_k     <= '0;
                    end
                end
                S_LOAD: begin
                    if (r_k == k_end) begin
                        r_state <= r_prod ? S_SUM : S_IDLE;
                        r_j     <= '0;
                    end else begin
                        r_k <= r_k + K_W'(1);
                    end
                end
                S_SUM: begin
                    if (r_j == POS_W'(WIN - 1)) begin
                        r_state <= S_CHAIN;
                        r_j     <= '0;
                    end else begin
                        r_j <= r_j + POS_W'(1);
                    end
                end
                S_CHAIN: begin
                    if (r_j == POS_W'(WIN - 1)) begin
                        r_state <= S_DIVGO;
                    end else begin
                        r_j <= r_j + POS_W'(1);
                    end
                end
                S_DIVGO: r_state <= S_DIV;
                S_DIV: begin
                    if (dv_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    // Cell commands
    assign ctl.shift_row = (r_state == S_LOAD) && (r_k == '0);
    assign ctl.push_col  = (r_state == S_LOAD) && (r_k != '0);
    assign ctl.acc_clr   = (r_state == S_LOAD) && (r_k == k_end);
    assign ctl.acc_en    = (r_state == S_SUM);
    assign ctl.chain_en  = (r_state == S_CHAIN);

    // Window rows are bottom-aligned: the newest row sits in the last cell
    for (genvar i = 0; i < WIN; i++) begin : g_cell
        logic [PIX_W-1:0] col_in;
        logic [SUM_W-1:0] psum_in;

        if (i == WIN - 1) begin : g_top
            assign col_in = push_data;
        end else begin : g_mid
            assign col_in = w_col[i+1];
        end
        if (i == 0) begin : g_first
            assign psum_in = '0;
        end else begin : g_rest
            assign psum_in = w_psum[i-1];
        end

        dmif_cell #(
            .WIN      (WIN),
            .CELL_IDX (i),
            .POS_W    (POS_W),
            .ACC_W    (ACC_W),
            .SUM_W    (SUM_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_pos  (r_j),
            .i_ctr  (ctr),
            .i_half (h_eff),
            .i_col  (col_in),
            .o_col  (w_col[i]),
            .i_psum (psum_in),
            .o_psum (w_psum[i])
        );
    end

    assign dv_start = (r_state == S_DIVGO);

    dmif_div #(
        .MAX_HALF (MAX_HALF),
        .HIDX_W   (HIDX_W),
        .NUM_W    (SUM_W),
        .DEN_W    (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (w_psum[WIN-1]),
        .i_half  (HIDX_W'(h_eff)),
        .o_done  (dv_done),
        .o_quo   (dv_quo)
    );

    // Output register: hold the result until the sink takes it
    assign out_load = (r_state == S_OUT) && (!r_out_vld || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= dv_quo[PIX_W-1:0];
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_load_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_k <= k_end))
        else $error("line store walk ran past the window height");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_vld && !i_m_axis_tready) |=> (r_state == S_OUT))
        else $error("result left the sequencer while the output was stalled");

    a_start_after_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_start |-> $past(r_state == S_CHAIN))
        else $error("divider launched without a completed partial-sum pass");

endmodule
